// ===== rtl/sfrc16_pkg.sv =====
// ---------------------------------------------------------------------------
// sfrc16_pkg: shared definitions for the sensor frame receiver
// Register map, frame constants and the byte-wide CRC-16/MODBUS update.
// ---------------------------------------------------------------------------
package sfrc16_pkg;

    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_SEED_RST    = 16'hFFFF;
    localparam logic [7:0]  START_BYTE_RST  = 8'hFE;
    localparam logic [7:0]  FUNC_A_RST      = 8'h44;
    localparam logic [7:0]  FUNC_B_RST      = 8'h04;
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = POS_W'(5);

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FUNC   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_VAL_HI = POS_W'(3);
    localparam logic [POS_W-1:0] POS_VAL_LO = POS_W'(4);

    typedef enum logic [1:0] {
        REG_CRC_SEED   = 2'd0,
        REG_START_BYTE = 2'd1,
        REG_FUNC_A     = 2'd2,
        REG_FUNC_B     = 2'd3
    } reg_idx_t;

    // one byte through the reflected CRC-16 register, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/sensor_frame_receiver_crc16_top.sv =====
// ---------------------------------------------------------------------------
// sensor_frame_receiver_crc16_top: sensor response frame receiver
// Hunts for a start byte, checks the function code, collects L+5 bytes and
// checks the CRC-16/MODBUS on the fly; one result transfer per frame.
// ---------------------------------------------------------------------------
//  channel  direction  width  contents
//  s_       in         8      rx_byte
//  m_       out        40     crc_ok, frame_value, held_value, value_seen
//  apb      in/out     32     crc_seed, start_byte, func_code_a, func_code_b
//
//  One byte is taken every cycle while s_tready is high; the CRC update and
//  position compare sit between the frame state and output registers.
//  A result appears on m_ the cycle after the frame's last byte transfer.
//  s_tready drops only while a result waits, m_tready is low and the next
//  byte would close a frame.
//  aresetn is synchronous, active low, and clears the frame state.
// ---------------------------------------------------------------------------
module sensor_frame_receiver_crc16_top
    import sfrc16_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // [7:0] rx_byte
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] crc_ok, [16:1] frame_value, [32:17] held_value, [33] value_seen,
    // [39:34] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [15:0]      crc_seed_reg;
    logic [7:0]       start_byte_reg;
    logic [7:0]       func_a_reg;
    logic [7:0]       func_b_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       val_hi_reg, val_hi_next;
    logic [7:0]       val_lo_reg, val_lo_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [15:0]      good_value_reg, good_value_next;
    logic             good_seen_reg, good_seen_next;

    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_valid_reg, m_valid_next;

    logic             s_hs;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic             in_body;
    logic             last_byte;
    logic [15:0]      crc_in;
    logic [15:0]      crc_upd;
    logic [15:0]      fv;
    logic             ok;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = reg_idx_t'(paddr[3:2]);

    // only the closing byte of a frame needs room in the output register
    assign s_tready = ~m_valid_reg | m_tready | ~last_byte;
    assign s_hs     = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---- configuration --------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_seed_reg   <= CRC_SEED_RST;
            start_byte_reg <= START_BYTE_RST;
            func_a_reg     <= FUNC_A_RST;
            func_b_reg     <= FUNC_B_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CRC_SEED:   crc_seed_reg   <= pwdata[15:0];
                REG_START_BYTE: start_byte_reg <= pwdata[7:0];
                REG_FUNC_A:     func_a_reg     <= pwdata[7:0];
                REG_FUNC_B:     func_b_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CRC_SEED:   prdata = {16'h0000, crc_seed_reg};
            REG_START_BYTE: prdata = {24'h000000, start_byte_reg};
            REG_FUNC_A:     prdata = {24'h000000, func_a_reg};
            REG_FUNC_B:     prdata = {24'h000000, func_b_reg};
            default:        prdata = '0;
        endcase
    end

    // ---- frame tracking -------------------------------------------------
    assign in_body   = (pos_reg >= POS_VAL_HI);
    assign last_byte = in_body && !((pos_reg + POS_W'(1)) < total_reg);
    // the start byte restarts the CRC from the seed
    assign crc_in    = (pos_reg == POS_HUNT) ? crc_seed_reg : crc_reg;
    assign crc_upd   = crc_feed(crc_in, s_tdata);

    // byte 4 may also be the last byte, so take it straight from the input
    assign fv  = {val_hi_reg, (pos_reg == POS_VAL_LO) ? s_tdata : val_lo_reg};
    assign ok  = (crc_reg[7:0] == crc_lo_reg) && (crc_reg[15:8] == s_tdata);

    always_comb begin
        pos_next        = pos_reg;
        total_next      = total_reg;
        crc_next        = crc_reg;
        val_hi_next     = val_hi_reg;
        val_lo_next     = val_lo_reg;
        crc_lo_next     = crc_lo_reg;
        good_value_next = good_value_reg;
        good_seen_next  = good_seen_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg & ~m_tready;

        if (s_hs) begin
            if (pos_reg == POS_HUNT) begin
                if (s_tdata == start_byte_reg) begin
                    crc_next = crc_upd;
                    pos_next = POS_FUNC;
                end
            end else if (pos_reg == POS_FUNC) begin
                if (s_tdata == func_a_reg || s_tdata == func_b_reg) begin
                    crc_next = crc_upd;
                    pos_next = POS_LEN;
                end else begin
                    pos_next = POS_HUNT;
                end
            end else if (pos_reg == POS_LEN) begin
                crc_next   = crc_upd;
                total_next = {1'b0, s_tdata} + FRAME_OVERHEAD;
                pos_next   = POS_VAL_HI;
            end else begin
                if (pos_reg == POS_VAL_HI) val_hi_next = s_tdata;
                if (pos_reg == POS_VAL_LO) val_lo_next = s_tdata;

                if ((pos_reg + POS_W'(2)) < total_reg) begin
                    crc_next = crc_upd;
                end else if ((pos_reg + POS_W'(2)) == total_reg) begin
                    crc_lo_next = s_tdata;
                end

                if (last_byte) begin
                    pos_next     = POS_HUNT;
                    m_valid_next = 1'b1;
                    if (ok) begin
                        good_value_next = fv;
                        good_seen_next  = 1'b1;
                    end
                    m_data_next = {6'b000000, ok | good_seen_reg,
                                   ok ? fv : good_value_reg, fv, ok};
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_HUNT;
            total_reg      <= '0;
            crc_reg        <= CRC_SEED_RST;
            val_hi_reg     <= '0;
            val_lo_reg     <= '0;
            crc_lo_reg     <= '0;
            good_value_reg <= '0;
            good_seen_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            total_reg      <= total_next;
            crc_reg        <= crc_next;
            val_hi_reg     <= val_hi_next;
            val_lo_reg     <= val_lo_next;
            crc_lo_reg     <= crc_lo_next;
            good_value_reg <= good_value_next;
            good_seen_reg  <= good_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // ---- assertions -----------------------------------------------------
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        in_body |-> (pos_reg < total_reg))
        else $error("byte position beyond frame length");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && last_byte) |=> (m_tvalid && pos_reg == POS_HUNT))
        else $error("frame end did not raise a result and rearm the hunt");

    a_seen_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        good_seen_reg |=> good_seen_reg)
        else $error("value_seen cleared without reset");

    a_good_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[32:17] == m_tdata[16:1] && m_tdata[33]))
        else $error("good frame not reflected in held value");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: sensor frame receiver with CRC-16/MODBUS check
// Streams received bytes into the block and checks every frame result
// against a local model of the frame parser and CRC. Frames are mostly well
// formed with random payloads; damaged, truncated and rejected frames and
// line noise are mixed in, under several register settings.
// ---------------------------------------------------------------------------
module testbench;
    import sfrc16_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 50;

    // fields of one result transfer, lowest bit last
    typedef struct packed {
        logic [5:0]  pad;
        logic        value_seen;
        logic [15:0] held_value;
        logic [15:0] frame_value;
        logic        crc_ok;
    } frame_result_t;

    class frame_scoreboard;
        logic [15:0]      crc_seed;
        logic [7:0]       start_byte;
        logic [7:0]       func_a;
        logic [7:0]       func_b;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] total;
        logic [15:0]      crc;
        logic [7:0]       val_hi;
        logic [7:0]       val_lo;
        logic [7:0]       crc_lo;
        logic [15:0]      good_value;
        logic             good_seen;
        frame_result_t    expected_frames[$];
        int               mismatches;

        function new();
            crc_seed   = CRC_SEED_RST;
            start_byte = START_BYTE_RST;
            func_a     = FUNC_A_RST;
            func_b     = FUNC_B_RST;
            pos        = POS_HUNT;
            total      = '0;
            crc        = CRC_SEED_RST;
            val_hi     = '0;
            val_lo     = '0;
            crc_lo     = '0;
            good_value = '0;
            good_seen  = 1'b0;
            mismatches = 0;
        endfunction

        // reflected poly, LSB first
        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                if (r[0])
                    r = (r >> 1) ^ 16'hA001;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_CRC_SEED:   crc_seed   = v[15:0];
                REG_START_BYTE: start_byte = v[7:0];
                REG_FUNC_A:     func_a     = v[7:0];
                REG_FUNC_B:     func_b     = v[7:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            frame_result_t r;
            logic          match;
            if (pos == POS_HUNT) begin
                if (b == start_byte) begin
                    crc = crc_update(crc_seed, b);
                    pos = POS_FUNC;
                end
            end else if (pos == POS_FUNC) begin
                if (b == func_a || b == func_b) begin
                    crc = crc_update(crc, b);
                    pos = POS_LEN;
                end else begin
                    pos = POS_HUNT;
                end
            end else if (pos == POS_LEN) begin
                crc   = crc_update(crc, b);
                total = {1'b0, b} + FRAME_OVERHEAD;
                pos   = POS_VAL_HI;
            end else begin
                if (pos == POS_VAL_HI) val_hi = b;
                if (pos == POS_VAL_LO) val_lo = b;
                if (pos + 2 < total)
                    crc = crc_update(crc, b);
                else if (pos + 2 == total)
                    crc_lo = b;
                if (pos + 1 < total) begin
                    pos = pos + 1'b1;
                end else begin
                    // CRC high byte closes the frame
                    pos   = POS_HUNT;
                    match = (crc[7:0] == crc_lo) && (crc[15:8] == b);
                    if (match) begin
                        good_value = {val_hi, val_lo};
                        good_seen  = 1'b1;
                    end
                    r.pad         = '0;
                    r.crc_ok      = match;
                    r.frame_value = {val_hi, val_lo};
                    r.held_value  = good_value;
                    r.value_seen  = good_seen;
                    expected_frames.push_back(r);
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_frame(logic [M_TDATA_W-1:0] tdata);
            frame_result_t got;
            frame_result_t want;
            got = frame_result_t'(tdata);
            if (expected_frames.size() == 0) begin
                report($sformatf("result %h with no frame pending", tdata));
                return;
            end
            want = expected_frames.pop_front();
            if (got.crc_ok !== want.crc_ok)
                report($sformatf("crc_ok got %b want %b", got.crc_ok, want.crc_ok));
            if (got.frame_value !== want.frame_value)
                report($sformatf("frame_value got %h want %h",
                                 got.frame_value, want.frame_value));
            if (got.held_value !== want.held_value)
                report($sformatf("held_value got %h want %h",
                                 got.held_value, want.held_value));
            if (got.value_seen !== want.value_seen)
                report($sformatf("value_seen got %b want %b",
                                 got.value_seen, want.value_seen));
            if (got.pad !== want.pad)
                report($sformatf("padding bits got %h", got.pad));
        endtask

        task flush();
            while (expected_frames.size() != 0) begin
                report($sformatf("frame result never arrived: %h",
                                 expected_frames.pop_front()));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_scoreboard sb;
    logic [7:0]      frame_buf[$];
    int              frame_items;
    int              cycle_count;
    bit              quiet;

    sensor_frame_receiver_crc16_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = quiet || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_frame(m_tdata);
    end

    // all driving tasks start and end just after a falling edge
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 16) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = b;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b);
        @(negedge aclk);
    endtask

    task automatic settle();
        int waited;
        waited   = 0;
        s_tvalid = 1'b0;
        while (sb.expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [15:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = {16'($urandom), val};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, pwdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] seed, input logic [7:0] start,
                              input logic [7:0] fa, input logic [7:0] fb);
        settle();
        apb_write(REG_CRC_SEED, seed);
        apb_write(REG_START_BYTE, {8'h00, start});
        apb_write(REG_FUNC_A, {8'h00, fa});
        apb_write(REG_FUNC_B, {8'h00, fb});
    endtask

    // fill < 0 gives a random payload
    task automatic build_frame(input int len, input logic [7:0] func,
                               input logic [15:0] seed, input int fill);
        logic [15:0] c;
        frame_buf.delete();
        frame_buf.push_back(sb.start_byte);
        frame_buf.push_back(func);
        frame_buf.push_back(8'(len));
        for (int i = 0; i < len; i++)
            frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        c = seed;
        foreach (frame_buf[i]) c = frame_scoreboard::crc_update(c, frame_buf[i]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    // damage flips one bit past the length byte, so the frame keeps its shape
    task automatic push_frame(input int first, input int upto, input bit damage);
        int k;
        if (damage) begin
            k = $urandom_range(3, frame_buf.size() - 1);
            frame_buf[k] ^= 8'(1 << $urandom_range(0, 7));
        end
        for (int i = first; i < upto; i++) begin
            send_byte(frame_buf[i]);
            frame_items++;
        end
    endtask

    task automatic random_phase(input bit with_long);
        int         target;
        int         pick;
        int         len;
        logic [7:0] func;
        logic [7:0] other;
        target = frame_items + PHASE_ITEMS;
        if (with_long) begin
            build_frame(255, sb.func_a, sb.crc_seed, -1);
            push_frame(0, frame_buf.size(), 1'b0);
            target += frame_buf.size();
        end
        while (frame_items < target) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
            func = $urandom_range(0, 1) ? sb.func_a : sb.func_b;
            build_frame(len, func, sb.crc_seed, -1);
            if (pick < 72) begin
                push_frame(0, frame_buf.size(), 1'b0);
            end else if (pick < 82) begin
                push_frame(0, frame_buf.size(), 1'b1);
            end else if (pick < 89) begin
                push_frame(0, $urandom_range(1, frame_buf.size() - 1), 1'b0);
            end else if (pick < 95) begin
                do other = 8'($urandom); while (other == sb.func_a || other == sb.func_b);
                frame_buf[1] = other;
                push_frame(0, 2 + $urandom_range(0, 3), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        sb          = new();
        frame_items = 0;
        quiet       = 1'b0;
        aresetn     = 1'b0;
        s_tdata     = '0;
        s_tvalid    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: empty payload reports the CRC bytes as the value
        build_frame(0, FUNC_A_RST, sb.crc_seed, -1);
        push_frame(0, frame_buf.size(), 1'b0);
        // rejected function code that is itself the start byte
        send_byte(START_BYTE_RST);
        send_byte(START_BYTE_RST);
        send_byte(FUNC_A_RST);
        build_frame(1, FUNC_B_RST, sb.crc_seed, 8'hFF);
        push_frame(0, frame_buf.size(), 1'b0);
        build_frame(2, FUNC_A_RST, sb.crc_seed, 8'h00);
        push_frame(0, frame_buf.size(), 1'b1);

        // registers change after the start byte: old seed, new code
        settle();
        build_frame(0, 8'h5A, sb.crc_seed, -1);
        push_frame(0, 1, 1'b0);
        settle();
        apb_write(REG_CRC_SEED, 16'h1D0F);
        apb_write(REG_FUNC_A, 16'h005A);
        push_frame(1, frame_buf.size(), 1'b0);

        set_config(16'h0000, 8'h00, 8'hFF, 8'h00);
        random_phase(1'b0);
        set_config(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
        random_phase(1'b0);
        set_config(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(1'b1);
        set_config(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        quiet = 1'b1;
        random_phase(1'b0);
        quiet = 1'b0;
        set_config(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(1'b0);
        set_config(CRC_SEED_RST, START_BYTE_RST, FUNC_A_RST, FUNC_B_RST);
        random_phase(1'b0);

        settle();
        sb.flush();
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
